@@ hdl/rrfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Reply frame decoder package
// Shared types, byte codes and decode weights for the reply frame decoder.
// ----------------------------------------------------------------------------
package rrfd_pkg;

  // Default depth of the frame byte store.
  localparam int STORE_DEPTH_DEFAULT = 16;

  // Frame byte codes.
  localparam logic [7:0] END_BYTE      = 8'hFD;
  localparam logic [7:0] RADIO_DEFAULT = 8'h94;
  localparam logic [7:0] OWN_DEFAULT   = 8'hE0;
  localparam logic [7:0] CMD_VOLUME    = 8'h14;
  localparam logic [7:0] SUB_VOLUME    = 8'h01;
  localparam logic [7:0] CMD_FREQ      = 8'h03;
  localparam logic [7:0] CMD_METER     = 8'h15;
  localparam logic [7:0] SUB_METER     = 8'h02;
  localparam logic [7:0] CMD_MODE      = 8'h04;

  // Frame positions that are decoded.
  localparam int FIRST_KEPT = 2;
  localparam int LAST_KEPT  = 9;

  // Configuration register indexes.
  localparam logic CFG_RADIO_ADDRESS = 1'b0;
  localparam logic CFG_OWN_ADDRESS   = 1'b1;

  // Number of packed BCD bytes handed to the decoder, least significant first.
  localparam int BCD_BYTES = 5;
  localparam int VALUE_W   = 34;

  // Weight of each BCD byte pair.
  localparam logic [BCD_BYTES-1:0][VALUE_W-1:0] WEIGHT = {
    34'd100000000, 34'd1000000, 34'd10000, 34'd100, 34'd1
  };

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_VOLUME = 2'd0,
    KIND_FREQ   = 2'd1,
    KIND_METER  = 2'd2,
    KIND_MODE   = 2'd3
  } kind_t;

  // One classified frame waiting for decode.
  typedef struct packed {
    kind_t                     kind;
    logic [BCD_BYTES-1:0][7:0] bcd;
  } entry_t;

endpackage

@@ hdl/rrfd_front.sv @@
// ----------------------------------------------------------------------------
// Reply frame decoder front end
// Stores received bytes by position, checks addresses on the end byte and
// classifies the frame into a normalized decode request.
// ----------------------------------------------------------------------------
module rrfd_front #(
  parameter int STORE_DEPTH = rrfd_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  logic                rx_valid,
  output logic                rx_ready,
  input  logic [7:0]          radio_address,
  input  logic [7:0]          own_address,
  input  logic                queue_full,
  output logic                push,
  output rrfd_pkg::entry_t    entry
);

  localparam int PW = $clog2(STORE_DEPTH + 1);

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [7:0]    store [rrfd_pkg::FIRST_KEPT:rrfd_pkg::LAST_KEPT];
  logic [7:0]    view  [rrfd_pkg::FIRST_KEPT:rrfd_pkg::LAST_KEPT];
  logic          accept;
  logic          is_end;
  logic          in_range;
  logic          addr_ok;
  logic          known;

  assign rx_ready = !queue_full;
  assign accept   = rx_valid && rx_ready;
  assign is_end   = (rx_byte == rrfd_pkg::END_BYTE);
  assign in_range = (pos < PW'(STORE_DEPTH));

  // The frame as it stands once the current byte has been written.
  always_comb begin
    for (int i = rrfd_pkg::FIRST_KEPT; i <= rrfd_pkg::LAST_KEPT; i++) begin
      view[i] = (in_range && pos == PW'(i)) ? rx_byte : store[i];
    end
  end

  always_comb begin
    if (is_end) begin
      pos_next = '0;
    end else if (in_range) begin
      pos_next = pos + PW'(1);
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      for (int i = rrfd_pkg::FIRST_KEPT; i <= rrfd_pkg::LAST_KEPT; i++) begin
        store[i] <= '0;
      end
    end else if (accept) begin
      pos <= pos_next;
      for (int i = rrfd_pkg::FIRST_KEPT; i <= rrfd_pkg::LAST_KEPT; i++) begin
        store[i] <= view[i];
      end
    end
  end

  // Classification. Every kind is mapped onto the frequency layout so the
  // back end needs a single weighted sum.
  assign addr_ok = (view[2] == own_address) && (view[3] == radio_address);

  always_comb begin
    known      = 1'b1;
    entry.kind = rrfd_pkg::KIND_MODE;
    entry.bcd  = '0;
    if (view[4] == rrfd_pkg::CMD_VOLUME && view[5] == rrfd_pkg::SUB_VOLUME) begin
      entry.kind   = rrfd_pkg::KIND_VOLUME;
      entry.bcd[0] = view[7];
      entry.bcd[1] = view[6];
    end else if (view[4] == rrfd_pkg::CMD_FREQ) begin
      entry.kind = rrfd_pkg::KIND_FREQ;
      for (int i = 0; i < rrfd_pkg::BCD_BYTES; i++) begin
        entry.bcd[i] = view[5 + i];
      end
    end else if (view[4] == rrfd_pkg::CMD_METER && view[5] == rrfd_pkg::SUB_METER) begin
      entry.kind   = rrfd_pkg::KIND_METER;
      entry.bcd[0] = view[7];
      entry.bcd[1] = view[6];
    end else if (view[4] == rrfd_pkg::CMD_MODE) begin
      entry.kind   = rrfd_pkg::KIND_MODE;
      entry.bcd[0] = view[5];
    end else begin
      known = 1'b0;
    end
  end

  assign push = accept && is_end && addr_ok && known;

endmodule

@@ hdl/rrfd_queue.sv @@
// ----------------------------------------------------------------------------
// Reply frame decoder queue
// Short first-in first-out buffer of classified frames between the front
// end and the decode back end.
// ----------------------------------------------------------------------------
module rrfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrfd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output rrfd_pkg::entry_t head
);

  localparam int AW = (rrfd_pkg::QUEUE_DEPTH > 1) ? $clog2(rrfd_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(rrfd_pkg::QUEUE_DEPTH + 1);

  rrfd_pkg::entry_t slot [rrfd_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(rrfd_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot[rd_ptr];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    if (p == AW'(rrfd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ hdl/rrfd_back.sv @@
// ----------------------------------------------------------------------------
// Reply frame decoder back end
// Two-stage BCD decode: weighted digit pairs, then their sum into the
// output register.
// ----------------------------------------------------------------------------
module rrfd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            queue_empty,
  input  rrfd_pkg::entry_t                head,
  output logic                            pop,
  output logic                            reply_valid,
  input  logic                            reply_ready,
  output logic [1:0]                      reply_kind,
  output logic [rrfd_pkg::VALUE_W-1:0]    reply_value,
  output logic                            mode_known
);

  localparam int N = rrfd_pkg::BCD_BYTES;
  localparam int W = rrfd_pkg::VALUE_W;

  logic [7:0]   pair [N];
  logic [W-1:0] term [N];
  logic         s1_valid;
  logic [1:0]   s1_kind;
  logic         s1_known;
  logic         s1_advance;
  logic         known_next;
  logic [W-1:0] sum;

  // Digit pair value: high nibble times ten plus low nibble.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      pair[i] = {1'b0, head.bcd[i][7:4], 3'b000} + {3'b000, head.bcd[i][7:4], 1'b0}
              + {4'b0000, head.bcd[i][3:0]};
    end
  end

  assign known_next = (head.kind == rrfd_pkg::KIND_MODE) &&
                      (pair[0] <= 8'd5 || pair[0] == 8'd7 || pair[0] == 8'd8);

  assign s1_advance = s1_valid && (!reply_valid || reply_ready);
  assign pop        = !queue_empty && (!s1_valid || s1_advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind  <= head.kind;
      s1_known <= known_next;
      for (int i = 0; i < N; i++) begin
        term[i] <= W'(pair[i]) * rrfd_pkg::WEIGHT[i];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < N; i++) begin
      sum = sum + term[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (s1_advance) begin
      reply_valid <= 1'b1;
    end else if (reply_ready) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      reply_kind  <= s1_kind;
      reply_value <= sum;
      mode_known  <= s1_known;
    end
  end

endmodule

@@ hdl/radio_reply_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// Radio reply frame decoder
// Assembles reply frames from received bus bytes and decodes volume,
// frequency, S-meter and mode replies from their packed BCD fields.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the rx channel (rx_byte, rx_valid, rx_ready), one
// request per byte. Each byte is stored at the current frame position; the
// end byte 0xFD closes the frame. When bytes 2 and 3 match own_address and
// radio_address and the command bytes name a known reply, one request leaves
// on the reply channel (reply_kind, reply_value, mode_known, reply_valid,
// reply_ready). Other frames produce nothing.
// Throughput is one byte per clock. The front end, a two-entry queue and a
// two-stage decode back end run independently, so rx_ready only drops when
// the queue is full, which happens only while the receiver holds reply_ready
// low. The queue is written when the end byte is accepted; the first decode
// stage loads from the queue and the output register, raising reply_valid,
// from that stage. The two addresses are written through cfg_write, cfg_index
// and cfg_data by the user only while the block is idle; the block does not
// enforce it. A synchronous reset restores the default addresses, clears the
// frame store and position, and empties the pipeline.
// ----------------------------------------------------------------------------
module radio_reply_frame_decoder #(
  parameter int STORE_DEPTH = rrfd_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   rx_byte,
  input  logic                         rx_valid,
  output logic                         rx_ready,
  output logic [1:0]                   reply_kind,
  output logic [rrfd_pkg::VALUE_W-1:0] reply_value,
  output logic                         mode_known,
  output logic                         reply_valid,
  input  logic                         reply_ready,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [7:0]                   cfg_data
);

  logic             [7:0] radio_address;
  logic             [7:0] own_address;
  logic                   push;
  logic                   pop;
  logic                   queue_full;
  logic                   queue_empty;
  rrfd_pkg::entry_t       push_entry;
  rrfd_pkg::entry_t       head;

  // Address registers; a write takes effect at the clock edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      radio_address <= rrfd_pkg::RADIO_DEFAULT;
      own_address   <= rrfd_pkg::OWN_DEFAULT;
    end else if (cfg_write) begin
      case (cfg_index)
        rrfd_pkg::CFG_RADIO_ADDRESS: radio_address <= cfg_data;
        rrfd_pkg::CFG_OWN_ADDRESS:   own_address   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: byte store, position counter, address check and classify.
  rrfd_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .radio_address(radio_address),
    .own_address  (own_address),
    .queue_full   (queue_full),
    .push         (push),
    .entry        (push_entry)
  );

  // Decouples classification from decode so each side stalls on its own.
  rrfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  // Back end: weighted BCD decode and the output register.
  rrfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .queue_empty(queue_empty),
    .head       (head),
    .pop        (pop),
    .reply_valid(reply_valid),
    .reply_ready(reply_ready),
    .reply_kind (reply_kind),
    .reply_value(reply_value),
    .mode_known (mode_known)
  );

endmodule
